[rtl/gaussian_kernel_generator_defines.svh]
// assertion macros for the gaussian kernel generator
// used by the top level, no other dependencies
`ifndef GAUSSIAN_KERNEL_GENERATOR_DEFINES_SVH
`define GAUSSIAN_KERNEL_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GKG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gkg check failed");
`define GKG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gkg check failed");
`else
`define GKG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GKG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/gkg_pkg.sv]
// shared types and constants for the gaussian kernel generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gkg_pkg;
    localparam int MAX_TAPS_DEF   = 63;
    localparam int RADIUS_MAX_DEF = 64;
    localparam int DIV_W  = 49;
    localparam int DVS_W  = 39;
    localparam int DW     = 6;
    localparam int RAW_W  = 33;
    localparam int SUM_W  = 35;
    localparam int PROD_W = 49;
    localparam int K_W    = 6;
    localparam int A_W    = 21;
    localparam logic [15:0]      LN2_Q16 = 16'd45426;
    localparam logic [DIV_W-1:0] A_LIMIT = 49'd1499058;
    localparam logic [3:0]       TERMS   = 4'd12;
    // floor(x/3) = (x * THIRD_RECIP) >> THIRD_SHIFT for x below 2^17
    localparam logic [16:0]      THIRD_RECIP = 17'd43691;
    localparam int               THIRD_SHIFT = 17;
    // floor(a/LN2_Q16) = (a * LN2_RECIP) >> LN2_SHIFT for a below 2^21
    localparam logic [21:0]      LN2_RECIP   = 22'd3025558;
    localparam int               LN2_SHIFT   = 37;

    typedef struct packed {
        logic        op;
        logic [15:0] sigma_q8;
        logic [6:0]  tap_count;
        logic [15:0] radius_q8;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  tap_index;
        logic [15:0] weight_q16;
        logic [6:0]  size_used;
        logic        error;
        logic        last;
    } t_out_word;

    typedef enum logic [2:0] {
        DS_A,
        DS_TERM,
        DS_NORM
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     set_sig;
        logic     set_size;
        logic     sq;
        logic     zero_raw;
        logic     cap_a;
        logic     set_k;
        logic     cap_k;
        logic     mul;
        logic     cap_term;
        logic     make_raw;
        logic     store;
        logic     norm_init;
        logic     rd;
        logic     out_tap;
        logic     out_err;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic invalid;
        logic div_done;
        logic div_busy;
        logic a_big;
        logic n_last;
        logic d_last;
        logic i_last;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

[rtl/gkg_div.sv]
// restoring divider, one quotient bit per cycle
// depends on gkg_pkg
`timescale 1ns / 1ps
`default_nettype none
module gkg_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [gkg_pkg::DIV_W-1:0]   i_dividend,
    input  wire [gkg_pkg::DVS_W-1:0]   i_divisor,
    output logic [gkg_pkg::DIV_W-1:0]  o_quot,
    output logic                       o_done,
    output logic                       o_busy
);
    import gkg_pkg::*;

    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
    assign o_busy = r_busy;
endmodule
`default_nettype wire

[rtl/gkg_dpath.sv]
// datapath: request registers, exp series, tap memory, normalization, output word
// depends on gkg_pkg and gkg_div
`timescale 1ns / 1ps
`default_nettype none
module gkg_dpath #(
    parameter int MAX_TAPS   = gkg_pkg::MAX_TAPS_DEF,
    parameter int RADIUS_MAX = gkg_pkg::RADIUS_MAX_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  gkg_pkg::t_in_word  i_in_data,
    input  wire                i_out_ready,
    input  gkg_pkg::t_cmd      i_cmd,
    output gkg_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output gkg_pkg::t_out_word o_out_data
);
    import gkg_pkg::*;

    localparam int DEPTH = MAX_TAPS / 2 + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [15:0] RAD_LIM = 16'(RADIUS_MAX * 256);

    logic              r_op;
    logic [15:0]       r_sigma;
    logic [15:0]       r_rad;
    logic [6:0]        r_size;
    logic [31:0]       r_s2;
    logic [DW-1:0]     r_d;
    logic [A_W-1:0]    r_a;
    logic [K_W-1:0]    r_k;
    logic [15:0]       r_r;
    logic [3:0]        r_n;
    logic [RAW_W-1:0]  r_term;
    logic signed [SUM_W-1:0] r_sum;
    logic [PROD_W-1:0] r_prod;
    logic [RAW_W-1:0]  r_raw;
    logic [DVS_W-1:0]  r_total;
    logic [6:0]        r_i;
    logic [RAW_W-1:0]  r_rd;
    logic              r_out_valid;
    t_out_word         r_out;
    logic [RAW_W-1:0]  mem [DEPTH];

    logic [DIV_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [DIV_W-1:0]  quot;
    logic              div_done;
    logic              div_busy;
    logic [DW-1:0]     centre;
    logic [6:0]        dist_i;
    logic [32:0]       sig_prod;
    logic [17:0]       six_sig;
    logic [9:0]        sz_raw;
    logic [6:0]        sz_op1;
    logic [11:0]       d_sq;
    logic [42:0]       k_prod;
    logic [21:0]       k_ln2;
    logic [A_W-1:0]    a_rem;
    logic [15:0]       weight;

    assign centre   = r_size[6:1];
    assign dist_i   = (r_i < {1'b0, centre}) ? ({1'b0, centre} - r_i) : (r_i - {1'b0, centre});
    assign sig_prod = 33'(r_rad) * 33'(THIRD_RECIP);
    assign six_sig  = 18'(r_sigma) * 18'd6;
    assign sz_raw   = six_sig[17:8] | 10'd1;
    assign sz_op1   = (sz_raw > 10'(MAX_TAPS)) ? 7'(MAX_TAPS)
                    : (sz_raw < 10'd3) ? 7'd3 : sz_raw[6:0];
    assign d_sq     = 12'(r_d) * 12'(r_d);
    assign k_prod   = 43'(r_a) * 43'(LN2_RECIP);
    assign k_ln2    = 22'(r_k) * 22'(LN2_Q16);
    assign a_rem    = r_a - k_ln2[A_W-1:0];
    assign weight   = (quot > DIV_W'(16'hFFFF)) ? 16'hFFFF : quot[15:0];

    always_comb begin
        case (i_cmd.div_sel)
            DS_A: begin
                div_dvd = DIV_W'({d_sq, 31'b0});
                div_dvs = DVS_W'(r_s2);
            end
            DS_TERM: begin
                div_dvd = DIV_W'(r_prod[PROD_W-1:16]);
                div_dvs = DVS_W'(r_n);
            end
            DS_NORM: begin
                div_dvd = DIV_W'({r_rd, 16'b0}) + DIV_W'(r_total >> 1);
                div_dvs = r_total;
            end
            default: begin
                div_dvd = '0;
                div_dvs = DVS_W'(1);
            end
        endcase
    end

    gkg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quot     (quot),
        .o_done     (div_done),
        .o_busy     (div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_data.op;
            r_sigma <= i_in_data.sigma_q8;
            r_size  <= i_in_data.tap_count;
            r_rad   <= (i_in_data.radius_q8 > RAD_LIM) ? RAD_LIM : i_in_data.radius_q8;
        end
        if (i_cmd.set_sig) begin
            r_sigma <= sig_prod[THIRD_SHIFT +: 16];
        end
        if (i_cmd.set_size) begin
            r_size <= sz_op1;
        end
        if (i_cmd.sq) begin
            r_s2    <= 32'(r_sigma) * 32'(r_sigma);
            r_d     <= '0;
            r_total <= '0;
        end
        if (i_cmd.cap_a) begin
            r_a <= quot[A_W-1:0];
        end
        if (i_cmd.zero_raw) begin
            r_raw <= '0;
        end
        if (i_cmd.set_k) begin
            r_k <= k_prod[LN2_SHIFT +: K_W];
        end
        if (i_cmd.cap_k) begin
            r_r    <= a_rem[15:0];
            r_term <= RAW_W'(33'h1_0000_0000);
            r_sum  <= SUM_W'(33'h1_0000_0000);
            r_n    <= 4'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_term) * PROD_W'(r_r);
        end
        if (i_cmd.cap_term) begin
            r_term <= quot[RAW_W-1:0];
            if (r_n[0]) begin
                r_sum <= r_sum - $signed(SUM_W'(quot[RAW_W-1:0]));
            end else begin
                r_sum <= r_sum + $signed(SUM_W'(quot[RAW_W-1:0]));
            end
            r_n <= r_n + 4'd1;
        end
        if (i_cmd.make_raw) begin
            r_raw <= r_sum[SUM_W-1] ? '0 : (r_sum[RAW_W-1:0] >> r_k);
        end
        if (i_cmd.store) begin
            r_total <= r_total + ((r_d == '0) ? DVS_W'(r_raw) : (DVS_W'(r_raw) << 1));
            r_d     <= r_d + DW'(1);
        end
        if (i_cmd.norm_init) begin
            r_i <= '0;
        end
        if (i_cmd.out_tap) begin
            r_i <= r_i + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_d[AW-1:0]] <= r_raw;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[dist_i[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_tap || i_cmd.out_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_tap) begin
            r_out.tap_index  <= r_i;
            r_out.weight_q16 <= weight;
            r_out.size_used  <= r_size;
            r_out.error      <= 1'b0;
            r_out.last       <= (r_i == r_size - 7'd1);
        end else if (i_cmd.out_err) begin
            r_out <= '{tap_index: 7'd0, weight_q16: 16'd0, size_used: 7'd0,
                       error: 1'b1, last: 1'b1};
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.invalid  = (r_size < 7'd3) || (r_size > 7'(MAX_TAPS)) || !r_size[0]
                          || (r_sigma == 16'd0);
    assign o_sts.div_done = div_done;
    assign o_sts.div_busy = div_busy;
    assign o_sts.a_big    = quot >= A_LIMIT;
    assign o_sts.n_last   = r_n == TERMS;
    assign o_sts.d_last   = r_d == centre;
    assign o_sts.i_last   = r_i == r_size - 7'd1;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

[rtl/gkg_ctrl.sv]
// controller state machine sequencing both passes over the taps
// depends on gkg_pkg
`timescale 1ns / 1ps
`default_nettype none
module gkg_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  gkg_pkg::t_sts  i_sts,
    output gkg_pkg::t_cmd  o_cmd
);
    import gkg_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_PRE    = 19'h00002,
        S_W_SIG  = 19'h00004,
        S_CHK    = 19'h00008,
        S_ERR    = 19'h00010,
        S_A_GO   = 19'h00020,
        S_A_W    = 19'h00040,
        S_K_GO   = 19'h00080,
        S_K_W    = 19'h00100,
        S_MUL    = 19'h00200,
        S_T_GO   = 19'h00400,
        S_T_W    = 19'h00800,
        S_RAW    = 19'h01000,
        S_ST     = 19'h02000,
        S_N_INIT = 19'h04000,
        S_RD     = 19'h08000,
        S_N_GO   = 19'h10000,
        S_N_W    = 19'h20000,
        S_OUT    = 19'h40000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DS_A;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                if (i_sts.op) begin
                    o_cmd.set_sig = 1'b1;
                    n_state       = S_W_SIG;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_W_SIG: begin
                o_cmd.set_size = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (i_sts.invalid) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.sq = 1'b1;
                    n_state  = S_A_GO;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_err = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_A_GO: begin
                o_cmd.div_sel   = DS_A;
                o_cmd.div_start = 1'b1;
                n_state         = S_A_W;
            end
            S_A_W: begin
                if (i_sts.div_done) begin
                    if (i_sts.a_big) begin
                        o_cmd.zero_raw = 1'b1;
                        n_state        = S_ST;
                    end else begin
                        o_cmd.cap_a = 1'b1;
                        n_state     = S_K_GO;
                    end
                end
            end
            S_K_GO: begin
                o_cmd.set_k = 1'b1;
                n_state     = S_K_W;
            end
            S_K_W: begin
                o_cmd.cap_k = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_T_GO;
            end
            S_T_GO: begin
                o_cmd.div_sel   = DS_TERM;
                o_cmd.div_start = 1'b1;
                n_state         = S_T_W;
            end
            S_T_W: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_term = 1'b1;
                    n_state        = i_sts.n_last ? S_RAW : S_MUL;
                end
            end
            S_RAW: begin
                o_cmd.make_raw = 1'b1;
                n_state        = S_ST;
            end
            S_ST: begin
                o_cmd.store = 1'b1;
                n_state     = i_sts.d_last ? S_N_INIT : S_A_GO;
            end
            S_N_INIT: begin
                o_cmd.norm_init = 1'b1;
                n_state         = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_N_GO;
            end
            S_N_GO: begin
                o_cmd.div_sel   = DS_NORM;
                o_cmd.div_start = 1'b1;
                n_state         = S_N_W;
            end
            S_N_W: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_tap = 1'b1;
                    n_state       = i_sts.i_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/gaussian_kernel_generator.sv]
// Gaussian kernel generator, top level: one request word in, one word per tap out.
// Input channel i_in_valid/o_in_ready carries op, sigma_q8, tap_count, radius_q8.
// Output channel o_out_valid/i_out_ready carries tap_index, weight_q16, size_used,
// error and last; the final word of a request has last set.
// A bad request (even, too small or too large size, or zero sigma) gives one
// error word. Op 1 derives sigma and size from the radius first.
// Pass one computes exp() for each distinct distance 0..size/2 on one shared
// 49-step divider, with 12 series terms per distance, each a multiply and a
// divide. Pass two normalizes each tap with one divide.
// A new request word is taken only when the previous one has been fully issued;
// the last output word may still be waiting in the output register then.
// When the receiver stalls, the sequencer holds before writing the output register.
// Reset is synchronous and active low; it returns the sequencer to idle and
// empties the output register. The tap memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_kernel_generator_defines.svh"
module gaussian_kernel_generator #(
    parameter int MAX_TAPS   = gkg_pkg::MAX_TAPS_DEF,
    parameter int RADIUS_MAX = gkg_pkg::RADIUS_MAX_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  gkg_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output gkg_pkg::t_out_word o_out_data
);
    import gkg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gkg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gkg_dpath #(
        .MAX_TAPS   (MAX_TAPS),
        .RADIUS_MAX (RADIUS_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `GKG_ASSERT_NOW(a_idle_div, i_clk, i_rst_n, o_in_ready, !sts.div_busy)
    `GKG_ASSERT_NOW(a_err_last, i_clk, i_rst_n, o_out_valid && o_out_data.error, o_out_data.last && o_out_data.size_used == 7'd0)
    `GKG_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, o_out_valid && !o_out_data.error, o_out_data.tap_index < o_out_data.size_used)
    `GKG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule
`default_nettype wire
